// ===== hdl/srsw_pkg.sv =====
// Shared constants and codes for the selective-repeat sender window.
// No dependencies; imported by selective_repeat_sender_window_core.
package srsw_pkg;

  localparam int WIN_SLOTS    = 4;
  localparam int SEQ_BITS     = 8;
  localparam int PAYLOAD_BITS = 64;

  localparam int SLOT_W = (WIN_SLOTS > 1) ? $clog2(WIN_SLOTS) : 1;

  // Port field widths (fixed by the item format)
  localparam int OP_W      = 2;
  localparam int SEQ_FLD_W = 8;
  localparam int PAY_FLD_W = 64;
  localparam int ACT_W     = 3;

  localparam int IN_TDATA_W  = 72;  // seq_num, payload
  localparam int IN_TUSER_W  = 3;   // op, checksum_ok
  localparam int OUT_TDATA_W = 80;  // out_seq, out_payload, window_full, pad
  localparam int OUT_TUSER_W = 3;   // action

  typedef logic [SEQ_BITS-1:0]     seq_t;
  typedef logic [SLOT_W-1:0]       slot_t;
  typedef logic [PAYLOAD_BITS-1:0] pay_t;

  localparam logic [OP_W-1:0] OP_SEND    = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

  localparam logic [ACT_W-1:0] ACT_SENT        = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REFUSED     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ACK_OK      = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ACK_DUP     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ACK_OUTSIDE = 3'd4;
  localparam logic [ACT_W-1:0] ACT_ACK_CORRUPT = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RESENT      = 3'd6;
  localparam logic [ACT_W-1:0] ACT_TO_IGNORED  = 3'd7;

endpackage

// ===== hdl/selective_repeat_sender_window_core.sv =====
// Selective-repeat ARQ sender window: payload ring memory, ack marks, window slide.
// Depends on srsw_pkg.
//
//  channel | dir | tdata (low bit up)                        | tuser (low bit up)
//  in_     | in  | seq_num[7:0], payload[71:8]               | op[1:0], checksum_ok[2]
//  out_    | out | out_seq[7:0], out_payload[71:8],          | action[2:0]
//          |     | window_full[72], zero[79:73]              |
//
// An item is latched and its payload memory read issued on accept in ST_IDLE;
// in ST_EXEC the core acts on the read data and loads the result register. An ack
// for the window base first goes through ST_SLIDE, which moves the base past each acked slot before loading the result.
// Reset clears window pointers and ack marks; payload slots are written before read.
// A result waiting in the output register does not block the next accept; the
// commit cycle waits while that register is full and out_tready is low.
module selective_repeat_sender_window_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [srsw_pkg::IN_TDATA_W-1:0]   in_tdata,   // seq_num, payload
  input  logic [srsw_pkg::IN_TUSER_W-1:0]   in_tuser,   // op, checksum_ok
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [srsw_pkg::OUT_TDATA_W-1:0]  out_tdata,  // out_seq, out_payload, window_full
  output logic [srsw_pkg::OUT_TUSER_W-1:0]  out_tuser   // action
);
  import srsw_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SLIDE} state_t;

  state_t                state_r, state_nxt;
  seq_t                  base_r, base_nxt;
  seq_t                  next_r, next_nxt;
  slot_t                 head_r, head_nxt;
  logic                  waiting_r, waiting_nxt;
  logic [WIN_SLOTS-1:0]  acked_r, acked_nxt;

  // latched item
  logic [OP_W-1:0]       op_r;
  seq_t                  seq_r;
  logic                  ck_r;
  pay_t                  pay_r;

  // result register
  logic                  ovalid_r, ovalid_nxt;
  logic [ACT_W-1:0]      oact_r, oact_nxt;
  logic [SEQ_FLD_W-1:0]  oseq_r, oseq_nxt;
  pay_t                  opay_r, opay_nxt;
  logic                  ofull_r, ofull_nxt;

  // payload memory
  pay_t                  mem [WIN_SLOTS];
  pay_t                  rd_data_r;
  slot_t                 rd_addr;
  slot_t                 wr_addr;
  logic                  wr_en;

  seq_t                  outs, in_seq, offset;
  logic                  full, in_win, out_free, accept;
  slot_t                 slot;

  // slot of sequence s: head + (s - base), offset below WIN_SLOTS here
  function automatic slot_t slot_of(input slot_t head, input seq_t off);
    logic [SLOT_W:0] sum;
    begin
      sum = (SLOT_W+1)'(head) + (SLOT_W+1)'(off);
      if (32'(sum) >= 32'(WIN_SLOTS)) sum = sum - (SLOT_W+1)'(WIN_SLOTS);
      slot_of = sum[SLOT_W-1:0];
    end
  endfunction

  function automatic slot_t slot_inc(input slot_t s);
    slot_inc = (32'(s) == WIN_SLOTS - 1) ? '0 : s + slot_t'(1);
  endfunction

  assign in_seq   = seq_t'(in_tdata[SEQ_FLD_W-1:0]);
  assign accept   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_free = !ovalid_r || out_tready;

  assign outs   = next_r - base_r;
  assign full   = 32'(outs) >= 32'(WIN_SLOTS);
  assign offset = seq_r - base_r;
  assign in_win = offset < outs;
  assign slot   = slot_of(head_r, offset);
  assign rd_addr = slot_of(head_r, in_seq - base_r);

  always_comb begin
    state_nxt   = state_r;
    base_nxt    = base_r;
    next_nxt    = next_r;
    head_nxt    = head_r;
    waiting_nxt = waiting_r;
    acked_nxt   = acked_r;
    ovalid_nxt  = ovalid_r && !out_tready;
    oact_nxt    = oact_r;
    oseq_nxt    = oseq_r;
    opay_nxt    = opay_r;
    ofull_nxt   = ofull_r;
    wr_en       = 1'b0;
    wr_addr     = slot_of(head_r, outs);
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          state_nxt  = ST_IDLE;
          ovalid_nxt = 1'b1;
          oseq_nxt   = SEQ_FLD_W'(seq_r);
          opay_nxt   = '0;
          ofull_nxt  = waiting_r;
          case (op_r)
            OP_SEND: begin
              oseq_nxt = SEQ_FLD_W'(next_r);
              if (full) begin
                waiting_nxt = 1'b1;
                oact_nxt    = ACT_REFUSED;
                ofull_nxt   = 1'b1;
              end else begin
                wr_en              = 1'b1;
                acked_nxt[wr_addr] = 1'b0;
                next_nxt           = next_r + seq_t'(1);
                waiting_nxt        = 32'(outs) + 1 >= WIN_SLOTS;
                oact_nxt           = ACT_SENT;
                opay_nxt           = pay_r;
                ofull_nxt          = waiting_nxt;
              end
            end
            OP_ACK: begin
              if (!ck_r) begin
                oact_nxt = ACT_ACK_CORRUPT;
              end else if (!in_win) begin
                oact_nxt = ACT_ACK_OUTSIDE;
              end else if (acked_r[slot]) begin
                oact_nxt = ACT_ACK_DUP;
              end else begin
                acked_nxt[slot] = 1'b1;
                if (offset == '0) begin
                  // result goes out once the base has moved
                  state_nxt  = ST_SLIDE;
                  ovalid_nxt = ovalid_r && !out_tready;
                end else begin
                  waiting_nxt = full;
                  oact_nxt    = ACT_ACK_OK;
                  ofull_nxt   = full;
                end
              end
            end
            OP_TIMEOUT: begin
              if (in_win && !acked_r[slot]) begin
                oact_nxt = ACT_RESENT;
                opay_nxt = rd_data_r;
              end else begin
                oact_nxt = ACT_TO_IGNORED;
              end
            end
            default: oact_nxt = ACT_TO_IGNORED;
          endcase
        end
      end
      ST_SLIDE: begin
        if (outs != '0 && acked_r[head_r]) begin
          acked_nxt[head_r] = 1'b0;
          base_nxt          = base_r + seq_t'(1);
          head_nxt          = slot_inc(head_r);
        end else if (out_free) begin
          state_nxt   = ST_IDLE;
          waiting_nxt = full;
          ovalid_nxt  = 1'b1;
          oact_nxt    = ACT_ACK_OK;
          oseq_nxt    = SEQ_FLD_W'(seq_r);
          opay_nxt    = '0;
          ofull_nxt   = full;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      base_r    <= '0;
      next_r    <= '0;
      head_r    <= '0;
      waiting_r <= 1'b0;
      acked_r   <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      base_r    <= base_nxt;
      next_r    <= next_nxt;
      head_r    <= head_nxt;
      waiting_r <= waiting_nxt;
      acked_r   <= acked_nxt;
      ovalid_r  <= ovalid_nxt;
      oact_r    <= oact_nxt;
      oseq_r    <= oseq_nxt;
      opay_r    <= opay_nxt;
      ofull_r   <= ofull_nxt;
      if (accept) begin
        op_r  <= in_tuser[OP_W-1:0];
        ck_r  <= in_tuser[OP_W];
        seq_r <= in_seq;
        pay_r <= pay_t'(in_tdata[SEQ_FLD_W +: PAY_FLD_W]);
      end
    end
  end

  // Write happens in the commit cycle; the next read can be issued no earlier than
  // the cycle after, so no bypass is needed. Read data holds while the commit waits.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= pay_r;
    if (accept) rd_data_r <= mem[rd_addr];
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = oact_r;
  assign out_tdata  = {(OUT_TDATA_W - SEQ_FLD_W - PAY_FLD_W - 1)'(0), ofull_r,
                       PAY_FLD_W'(opay_r), oseq_r};

  a_outs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(outs) <= WIN_SLOTS)
    else $error("outstanding count exceeds window size");

  // during a slide the flag is refreshed only when the slide finishes
  a_wait_full: assert property (@(posedge clk) disable iff (!rst_n)
    (waiting_r && state_r != ST_SLIDE) |-> full)
    else $error("waiting flag set while window not full");

  a_slide_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && outs != '0) |-> !acked_r[head_r])
    else $error("acked packet left at window base");

  a_slide_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && state_nxt == ST_SLIDE) |=> (acked_r[head_r] && outs != '0))
    else $error("slide entered without acked base");

endmodule
